>>> sv/qrs_pkg.sv
package qrs_pkg;

    localparam int OUT_BITS = 40;

    // status and sign flags that ride along the divider cells
    typedef struct packed {
        logic a_zero;
        logic cmplx;
        logic neg1;
        logic neg2;
    } t_div_side;

endpackage

>>> sv/qrs_sqrt_cell.sv
module qrs_sqrt_cell #(
    parameter int RW  = 50,
    parameter int SW  = 25,
    parameter int SBW = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [RW-1:0]  i_rad,
    input  logic [SW:0]    i_rem,
    input  logic [SW-1:0]  i_root,
    input  logic [SBW-1:0] i_side,
    output logic           o_valid,
    output logic [RW-1:0]  o_rad,
    output logic [SW:0]    o_rem,
    output logic [SW-1:0]  o_root,
    output logic [SBW-1:0] o_side
);

    logic [SW+2:0] rem_sh;
    logic [SW+2:0] trial;
    logic [SW+2:0] diff;
    logic          ge;
    logic [SW:0]   n_rem;
    logic [SW-1:0] n_root;
    logic [RW-1:0] n_rad;

    logic           r_valid;
    logic [RW-1:0]  r_rad;
    logic [SW:0]    r_rem;
    logic [SW-1:0]  r_root;
    logic [SBW-1:0] r_side;

    // one root digit: bring down two radicand bits, try root*4+1
    always_comb begin
        rem_sh = {i_rem, i_rad[RW-1:RW-2]};
        trial  = {1'b0, i_root, 2'b01};
        diff   = rem_sh - trial;
        ge     = (rem_sh >= trial);
        n_rem  = ge ? diff[SW:0] : rem_sh[SW:0];
        n_root = {i_root[SW-2:0], ge};
        n_rad  = {i_rad[RW-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= n_rad;
            r_rem  <= n_rem;
            r_root <= n_root;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rad   = r_rad;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_side  = r_side;

endmodule

>>> sv/qrs_div_cell.sv
module qrs_div_cell
    import qrs_pkg::*;
#(
    parameter int QW  = 33,
    parameter int DNW = 17
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [DNW-1:0]        i_den,
    input  logic [1:0][QW-1:0]    i_num,
    input  logic [1:0][DNW-1:0]   i_rem,
    input  logic [1:0][QW-1:0]    i_quo,
    input  t_div_side             i_side,
    output logic                  o_valid,
    output logic [DNW-1:0]        o_den,
    output logic [1:0][QW-1:0]    o_num,
    output logic [1:0][DNW-1:0]   o_rem,
    output logic [1:0][QW-1:0]    o_quo,
    output t_div_side             o_side
);

    logic [1:0][DNW:0]   rem_sh;
    logic [1:0][DNW:0]   diff;
    logic [1:0]          ge;
    logic [1:0][QW-1:0]  n_num;
    logic [1:0][DNW-1:0] n_rem;
    logic [1:0][QW-1:0]  n_quo;

    logic                r_valid;
    logic [DNW-1:0]      r_den;
    logic [1:0][QW-1:0]  r_num;
    logic [1:0][DNW-1:0] r_rem;
    logic [1:0][QW-1:0]  r_quo;
    t_div_side           r_side;

    // restoring step on both lanes, sharing the divisor
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            rem_sh[l] = {i_rem[l], i_num[l][QW-1]};
            diff[l]   = rem_sh[l] - {1'b0, i_den};
            ge[l]     = (rem_sh[l] >= {1'b0, i_den});
            n_rem[l]  = ge[l] ? diff[l][DNW-1:0] : rem_sh[l][DNW-1:0];
            n_quo[l]  = {i_quo[l][QW-2:0], ge[l]};
            n_num[l]  = {i_num[l][QW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den  <= i_den;
            r_num  <= n_num;
            r_rem  <= n_rem;
            r_quo  <= n_quo;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_den   = r_den;
    assign o_num   = r_num;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;
    assign o_side  = r_side;

endmodule

>>> sv/quadratic_root_solver_top.sv
// Quadratic root solver: takes signed coefficients a, b, c and returns either the two real
// roots (-b +/- sqrt(d))/(2a) or, for a negative discriminant, the real part -b/(2a) and the
// imaginary part sqrt(|d|)/(2a), all with FRAC_BITS fractional bits, truncated toward zero
// and saturated to 40 bits; a zero a gives status 1 and zero fields. One item is accepted
// every cycle while the output is not stalled. Each item passes the product register, the set-up
// register, the row of square root cells (one root bit each), the numerator register, the row
// of divider cells (one quotient bit each) and the output register.
module quadratic_root_solver_top
    import qrs_pkg::*;
#(
    parameter int COEF_BITS = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [COEF_BITS-1:0] i_coef_a,
    input  logic signed [COEF_BITS-1:0] i_coef_b,
    input  logic signed [COEF_BITS-1:0] i_coef_c,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_status,
    output logic                        o_is_complex,
    output logic signed [OUT_BITS-1:0]  o_first_value,
    output logic signed [OUT_BITS-1:0]  o_second_value
);

    localparam int C    = COEF_BITS;
    localparam int H    = FRAC_BITS / 2;
    localparam int DW   = 2 * C + 2;
    localparam int MW   = 2 * C + 1;
    localparam int SW   = C + H + 1;
    localparam int RW   = 2 * SW;
    localparam int NBW  = C + H + 1;
    localparam int NSW  = C + H + 2;
    localparam int DNW  = C + 1;
    localparam int QW   = C + FRAC_BITS + 1;
    localparam int SBW  = 3 + NBW + DNW;
    localparam int EW   = ((QW > OUT_BITS) ? QW : OUT_BITS) + 1;

    logic adv;

    // front: products
    logic                  r_v1;
    logic signed [C-1:0]   r_a1;
    logic signed [C-1:0]   r_b1;
    logic signed [2*C-1:0] r_bb;
    logic signed [2*C-1:0] r_ac;

    // discriminant and operand set-up
    logic signed [DW-1:0]  d_w;
    logic [MW-1:0]         mag_w;
    logic signed [NBW-1:0] nb_w;
    logic signed [C:0]     a_ext;
    logic [C:0]            a_abs;
    logic [SBW-1:0]        n_side2;
    logic                  r_v2;
    logic [RW-1:0]         r_rad2;
    logic [SBW-1:0]        r_side2;

    logic                  sq_valid [SW+1];
    logic [RW-1:0]         sq_rad   [SW+1];
    logic [SW:0]           sq_rem   [SW+1];
    logic [SW-1:0]         sq_root  [SW+1];
    logic [SBW-1:0]        sq_side  [SW+1];

    // numerators
    logic                  s3_a_zero;
    logic                  s3_d_neg;
    logic                  s3_a_neg;
    logic signed [NBW-1:0] s3_nb;
    logic [DNW-1:0]        s3_den;
    logic signed [NSW-1:0] nbe;
    logic signed [NSW-1:0] se;
    logic signed [NSW-1:0] num1;
    logic signed [NSW-1:0] num2;
    logic signed [NSW-1:0] abs1;
    logic signed [NSW-1:0] abs2;
    t_div_side             n_dside3;
    logic                  r_v3;
    logic [DNW-1:0]        r_den3;
    logic [1:0][QW-1:0]    r_num3;
    t_div_side             r_dside3;

    logic                  dv_valid [QW+1];
    logic [DNW-1:0]        dv_den   [QW+1];
    logic [1:0][QW-1:0]    dv_num   [QW+1];
    logic [1:0][DNW-1:0]   dv_rem   [QW+1];
    logic [1:0][QW-1:0]    dv_quo   [QW+1];
    t_div_side             dv_side  [QW+1];

    // output
    logic [1:0][EW-1:0]       q_e;
    logic [1:0][OUT_BITS-1:0] res;
    logic [EW-1:0]            lim_n;
    logic [EW-1:0]            lim_p;
    t_div_side                fin;
    logic                     r_out_valid;
    logic                     r_status;
    logic                     r_cmplx;
    logic [OUT_BITS-1:0]      r_first;
    logic [OUT_BITS-1:0]      r_second;

    assign adv     = !r_out_valid || !i_stall;
    assign o_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= sq_valid[SW];
            r_out_valid <= dv_valid[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a1 <= i_coef_a;
            r_b1 <= i_coef_b;
            r_bb <= i_coef_b * i_coef_b;
            r_ac <= i_coef_a * i_coef_c;
        end
    end

    always_comb begin
        d_w     = DW'(r_bb) - (DW'(r_ac) <<< 2);
        mag_w   = d_w[DW-1] ? MW'(-d_w) : MW'(d_w);
        nb_w    = (-NBW'(r_b1)) <<< H;
        a_ext   = (C+1)'(r_a1);
        a_abs   = a_ext[C] ? (-a_ext) : a_ext;
        n_side2 = {(r_a1 == '0), d_w[DW-1], r_a1[C-1], nb_w, a_abs[C-1:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rad2  <= RW'(mag_w) << (2 * H);
            r_side2 <= n_side2;
        end
    end

    assign sq_valid[0] = r_v2;
    assign sq_rad[0]   = r_rad2;
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;
    assign sq_side[0]  = r_side2;

    for (genvar k = 0; k < SW; k++) begin : g_sqrt
        qrs_sqrt_cell #(.RW(RW), .SW(SW), .SBW(SBW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_valid (sq_valid[k]),
            .i_rad   (sq_rad[k]),
            .i_rem   (sq_rem[k]),
            .i_root  (sq_root[k]),
            .i_side  (sq_side[k]),
            .o_valid (sq_valid[k+1]),
            .o_rad   (sq_rad[k+1]),
            .o_rem   (sq_rem[k+1]),
            .o_root  (sq_root[k+1]),
            .o_side  (sq_side[k+1])
        );
    end

    always_comb begin
        {s3_a_zero, s3_d_neg, s3_a_neg, s3_nb, s3_den} = sq_side[SW];
        nbe  = NSW'(s3_nb);
        se   = {1'b0, sq_root[SW]};
        num1 = s3_d_neg ? nbe : (nbe + se);
        num2 = s3_d_neg ? se : (nbe - se);
        abs1 = num1[NSW-1] ? (-num1) : num1;
        abs2 = num2[NSW-1] ? (-num2) : num2;
        n_dside3.a_zero = s3_a_zero;
        n_dside3.cmplx  = s3_d_neg;
        n_dside3.neg1   = num1[NSW-1] ^ s3_a_neg;
        n_dside3.neg2   = num2[NSW-1] ^ s3_a_neg;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_den3    <= s3_den;
            r_num3[0] <= QW'(abs1[NSW-2:0]) << (FRAC_BITS - H);
            r_num3[1] <= QW'(abs2[NSW-2:0]) << (FRAC_BITS - H);
            r_dside3  <= n_dside3;
        end
    end

    assign dv_valid[0] = r_v3;
    assign dv_den[0]   = r_den3;
    assign dv_num[0]   = r_num3;
    assign dv_rem[0]   = '0;
    assign dv_quo[0]   = '0;
    assign dv_side[0]  = r_dside3;

    for (genvar k = 0; k < QW; k++) begin : g_div
        qrs_div_cell #(.QW(QW), .DNW(DNW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_valid (dv_valid[k]),
            .i_den   (dv_den[k]),
            .i_num   (dv_num[k]),
            .i_rem   (dv_rem[k]),
            .i_quo   (dv_quo[k]),
            .i_side  (dv_side[k]),
            .o_valid (dv_valid[k+1]),
            .o_den   (dv_den[k+1]),
            .o_num   (dv_num[k+1]),
            .o_rem   (dv_rem[k+1]),
            .o_quo   (dv_quo[k+1]),
            .o_side  (dv_side[k+1])
        );
    end

    // sign and saturate each quotient into the 40-bit field
    always_comb begin
        fin   = dv_side[QW];
        lim_n = EW'(1) << (OUT_BITS - 1);
        lim_p = lim_n - EW'(1);
        for (int l = 0; l < 2; l++) begin
            q_e[l] = EW'(dv_quo[QW][l]);
        end
        if (fin.neg1) begin
            if (q_e[0] > lim_n) q_e[0] = lim_n;
            res[0] = OUT_BITS'(-q_e[0]);
        end else begin
            if (q_e[0] > lim_p) q_e[0] = lim_p;
            res[0] = OUT_BITS'(q_e[0]);
        end
        if (fin.neg2) begin
            if (q_e[1] > lim_n) q_e[1] = lim_n;
            res[1] = OUT_BITS'(-q_e[1]);
        end else begin
            if (q_e[1] > lim_p) q_e[1] = lim_p;
            res[1] = OUT_BITS'(q_e[1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_status <= fin.a_zero;
            r_cmplx  <= fin.a_zero ? 1'b0 : fin.cmplx;
            r_first  <= fin.a_zero ? '0 : res[0];
            r_second <= fin.a_zero ? '0 : res[1];
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_is_complex   = r_cmplx;
    assign o_first_value  = r_first;
    assign o_second_value = r_second;

`ifndef SYNTHESIS
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (!o_is_complex && o_first_value == '0
                                   && o_second_value == '0))
        else $error("zero a item carries nonzero fields");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_v1)
        else $error("accepted item not in first stage");

    a_hold_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> ($stable(r_v1) && $stable(r_v3)))
        else $error("pipeline moved while output stalled");
`endif

endmodule
